FILE: hw/rtl/lpht_pkg.sv
// shared types and constants of the linear-probing hash table
package lpht_pkg;

	// key and reported slot widths
	localparam int KEY_W   = 16;
	localparam int SLOT_W  = 4;

	// request kinds
	typedef enum logic [1:0] {
		KIND_INSERT = 2'd0,
		KIND_SEARCH = 2'd1,
		KIND_CLEAR  = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	// result status codes
	typedef enum logic [1:0] {
		STAT_DONE  = 2'd0,
		STAT_FOUND = 2'd1,
		STAT_MISS  = 2'd2,
		STAT_FULL  = 2'd3
	} status_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_HASH,
		ST_READ,
		ST_CHECK,
		ST_CLEAR
	} state_t;

	// request transaction
	typedef struct packed {
		kind_t              kind;
		logic [KEY_W-1:0]   key;
	} req_t;

	// result transaction
	typedef struct packed {
		status_t            status;
		logic [SLOT_W-1:0]  slot;
	} rsp_t;

endpackage

FILE: hw/rtl/lpht_mod.sv
// key-modulo-table-size unit by reciprocal multiplication; key, quotient and remainder are registered in turn
module lpht_mod #(
	parameter int DIVISOR = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [lpht_pkg::KEY_W-1:0]    dividend,
	output logic                          done,
	output logic [$clog2(DIVISOR)-1:0]    rem
);
	import lpht_pkg::*;

	localparam int AW = $clog2(DIVISOR);
	// quotient is (key * RECIP) >> K, exact for every key of KEY_W bits
	localparam int K  = KEY_W + AW;
	localparam longint unsigned RECIP =
		((longint'(1) << K) + longint'(DIVISOR) - 1) / longint'(DIVISOR);
	localparam int PW = (2 * KEY_W + 2 > K + AW) ? 2 * KEY_W + 2 : K + AW;

	logic              mul_q;
	logic              sub_q;
	logic              done_q;
	logic [KEY_W-1:0]  key_q;
	logic [AW-1:0]     quot_q;
	logic [AW-1:0]     rem_q;
	logic [PW-1:0]     prod;
	logic [AW-1:0]     back;

	// scaled quotient, only its low bits matter for the remainder
	assign prod = PW'(key_q) * PW'(RECIP);
	// low bits of quotient times divisor
	assign back = quot_q * AW'(DIVISOR);

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_q  <= 1'b0;
			sub_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			mul_q  <= start;
			sub_q  <= mul_q;
			done_q <= sub_q;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			key_q <= dividend;
		end
		if (mul_q) begin
			quot_q <= prod[K +: AW];
		end
		if (sub_q) begin
			rem_q <= key_q[AW-1:0] - back;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

FILE: hw/rtl/linear_probe_hash_table_core.sv
// open-addressing hash table with linear probing, sequencer and slot memory
// insert or search first take the home slot remainder from lpht_mod, then probe
//   slot after slot, each probe a memory read (ST_READ) and a compare (ST_CHECK)
// clear sweeps the slot memory at one slot per cycle
// one transaction at a time, busy high until done; an unused kind answers next cycle without raising busy
// after reset a clearing pass over every slot runs with busy high
// each result shows on rsp with a one-cycle done strobe and stays until the next; the receiver cannot stall
module linear_probe_hash_table_core #(
	parameter int TABLE_SIZE = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  lpht_pkg::req_t   req,
	output logic             busy,
	output logic             done,
	output lpht_pkg::rsp_t   rsp
);
	import lpht_pkg::*;

	localparam int AW = $clog2(TABLE_SIZE);
	localparam int CW = $clog2(TABLE_SIZE + 1);

	state_t            state_q, state_d;
	req_t              req_q;
	logic [AW-1:0]     addr_q, addr_d;
	logic [CW-1:0]     cnt_q, cnt_d;
	logic [CW-1:0]     cnt_next;
	logic [AW-1:0]     addr_next;
	logic              accept;
	logic              mod_done;
	logic [AW-1:0]     mod_rem;
	logic              mem_we;
	logic [KEY_W:0]    mem_wdata;
	logic [KEY_W:0]    mem [TABLE_SIZE];
	logic [KEY_W:0]    rd_q;
	logic              rd_used;
	logic [KEY_W-1:0]  rd_key;
	logic              done_q, done_d;
	rsp_t              rsp_q, rsp_d;
	logic [AW+SLOT_W-1:0] slot_ext;
	logic [SLOT_W-1:0] slot_cur;

	assign accept  = start && (state_q == ST_IDLE);
	assign rd_used = rd_q[KEY_W];
	assign rd_key  = rd_q[KEY_W-1:0];

	// probe step, wrapping at the last slot
	assign cnt_next  = cnt_q + 1'b1;
	assign addr_next = (addr_q == AW'(TABLE_SIZE - 1)) ? '0 : addr_q + 1'b1;

	// reported slot is the low bits of the address
	assign slot_ext = {{SLOT_W{1'b0}}, addr_q};
	assign slot_cur = slot_ext[SLOT_W-1:0];

	// home slot remainder
	lpht_mod #(
		.DIVISOR (TABLE_SIZE)
	) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept && (req.kind == KIND_INSERT || req.kind == KIND_SEARCH)),
		.dividend (req.key),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	// state register and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			addr_q  <= '0;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			addr_q  <= addr_d;
			cnt_q   <= cnt_d;
			done_q  <= done_d;
		end
	end

	// request and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		rsp_q <= rsp_d;
	end

	// slot memory: used flag over key, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[addr_q] <= mem_wdata;
		end
		rd_q <= mem[addr_q];
	end

	// sequencer
	always_comb begin
		state_d   = state_q;
		addr_d    = addr_q;
		cnt_d     = cnt_q;
		mem_we    = 1'b0;
		mem_wdata = '0;
		done_d    = 1'b0;
		rsp_d     = rsp_q;
		unique case (state_q)
			ST_INIT, ST_CLEAR: begin
				mem_we = 1'b1;
				if (addr_q == AW'(TABLE_SIZE - 1)) begin
					addr_d  = '0;
					state_d = ST_IDLE;
					if (state_q == ST_CLEAR) begin
						done_d = 1'b1;
						rsp_d  = '{status: STAT_DONE, slot: '0};
					end
				end else begin
					addr_d = addr_q + 1'b1;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					unique case (req.kind)
						KIND_INSERT, KIND_SEARCH: state_d = ST_HASH;
						KIND_CLEAR: begin
							addr_d  = '0;
							state_d = ST_CLEAR;
						end
						default: begin
							done_d = 1'b1;
							rsp_d  = '{status: STAT_MISS, slot: '0};
						end
					endcase
				end
			end
			ST_HASH: begin
				if (mod_done) begin
					addr_d  = mod_rem;
					cnt_d   = '0;
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (req_q.kind == KIND_INSERT && !rd_used) begin
					mem_we    = 1'b1;
					mem_wdata = {1'b1, req_q.key};
					done_d    = 1'b1;
					rsp_d     = '{status: STAT_DONE, slot: slot_cur};
					state_d   = ST_IDLE;
				end else if (req_q.kind == KIND_SEARCH && !rd_used) begin
					done_d  = 1'b1;
					rsp_d   = '{status: STAT_MISS, slot: '0};
					state_d = ST_IDLE;
				end else if (req_q.kind == KIND_SEARCH && rd_key == req_q.key) begin
					done_d  = 1'b1;
					rsp_d   = '{status: STAT_FOUND, slot: slot_cur};
					state_d = ST_IDLE;
				end else if (cnt_next == CW'(TABLE_SIZE)) begin
					// one full wrap without a free slot or a hit
					done_d  = 1'b1;
					rsp_d   = '{status: (req_q.kind == KIND_INSERT) ? STAT_FULL : STAT_MISS,
						slot: '0};
					state_d = ST_IDLE;
				end else begin
					addr_d  = addr_next;
					cnt_d   = cnt_next;
					state_d = ST_READ;
				end
			end
			default: state_d = ST_INIT;
		endcase
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

	// a result always leaves the block ready for the next transaction
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobed while busy");

	// probe count never passes one full wrap
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(TABLE_SIZE))
		else $error("probe count beyond table size");

	// a compare always follows its memory read
	a_check_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CHECK |-> $past(state_q) == ST_READ)
		else $error("compare without read");

	// insert only writes into an empty slot
	a_write_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && state_q == ST_CHECK) |-> !rd_used)
		else $error("insert overwrote a used slot");

	// clear request starts the sweep at slot zero
	a_clear_start: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.kind == KIND_CLEAR) |=> (state_q == ST_CLEAR && addr_q == '0))
		else $error("clear sweep did not start");

endmodule
